// ===== rtl/core/tpf_pkg.sv =====
// ----------------------------------------------------------------------------
// tpf_pkg
// Shared constants and types for the three-level priority FIFO core.
// ----------------------------------------------------------------------------
package tpf_pkg;

  // Ring depth per level and number of levels
  localparam int DEPTH  = 16;
  localparam int LEVELS = 3;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int MEM_DEPTH = LEVELS * DEPTH;
  localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [7:0] EMPTY_BYTE = 8'h20;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Priority request codes that pick a specific level
  localparam logic [1:0] PRIO_ONE = 2'd1;
  localparam logic [1:0] PRIO_TWO = 2'd2;

  // Level indexes
  localparam logic [LVL_W-1:0] LVL_ONE   = LVL_W'(0);
  localparam logic [LVL_W-1:0] LVL_TWO   = LVL_W'(1);
  localparam logic [LVL_W-1:0] LVL_THREE = LVL_W'(2);

  // Result status codes
  localparam logic [1:0] ST_PUSH_OK   = 2'd0;
  localparam logic [1:0] ST_POP_OK    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_ALL_EMPTY = 2'd3;

  // Memory command from the pointer bank for the current request
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
  } mem_cmd_t;

endpackage

// ===== rtl/core/three_level_priority_fifo_core.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_fifo_core
// Three byte FIFOs, one per priority level, behind one request stream.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel. s_tuser carries the operation (push or
//   pop) and the priority; s_tdata carries the byte to push. Each request
//   transaction yields exactly one result transaction on the m_ channel:
//   m_tdata is the popped byte (0x20 if every level is empty, zero on push)
//   and m_tuser is the status code.
//   A push result is in the output register in the cycle after the
//   request; a pop result first passes through the registered read of the
//   level store before it reaches the output register.
//   One push per cycle while the receiver takes results; a pop holds off
//   the next request until its byte is back from the registered read of
//   the store RAM.
//   A push into a full level is dropped and reported as overflow.
//   Reset clears every pointer and fill count, so all levels read empty;
//   store contents are not cleared and need no clearing pass.
//   When the receiver stalls (m_tready low) the result holds in the output
//   register and s_tready drops until it is taken.
// ----------------------------------------------------------------------------
module three_level_priority_fifo_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data
  input  logic [2:0] s_tuser,   // [0] operation, [2:1] priority_req
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] result_byte
  output logic [1:0] m_tuser    // [1:0] status
);

  tpf_pkg::mem_cmd_t cmd;
  logic              take;
  logic              rd_pending;  // pop read in flight, byte lands next cycle
  logic              out_free;
  logic [7:0]        rd_data;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !rd_pending && out_free;
  assign take     = s_tvalid && s_tready;

  tpf_ptrs u_ptrs (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .operation    (s_tuser[0]),
    .priority_req (s_tuser[2:1]),
    .cmd          (cmd)
  );

  // Level store: level index times DEPTH plus ring position
  tpf_ram #(
    .WIDTH (8),
    .DEPTH (tpf_pkg::MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (take && cmd.wr_en),
    .waddr (cmd.addr),
    .wdata (s_tdata),
    .re    (take && cmd.rd_en),
    .raddr (cmd.addr),
    .rdata (rd_data)
  );

  // Output register. Accepting a request implies the register is free
  // at that edge, and no new request enters while a read is pending.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      if (rd_pending) begin
        m_tvalid   <= 1'b1;
        rd_pending <= 1'b0;
      end else if (take) begin
        m_tvalid   <= !cmd.rd_en;
        rd_pending <= cmd.rd_en;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      m_tdata <= rd_data;
    end else if (take) begin
      m_tuser <= cmd.status;
      m_tdata <= (cmd.status == tpf_pkg::ST_ALL_EMPTY) ? tpf_pkg::EMPTY_BYTE : 8'h00;
    end
  end

endmodule

// ===== rtl/core/tpf_ram.sv =====
// ----------------------------------------------------------------------------
// tpf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/tpf_ptrs.sv =====
// ----------------------------------------------------------------------------
// tpf_ptrs
// Per-level read/write positions and fill counts; turns a request into a
// memory command and a status, and advances the pointers on acceptance.
// ----------------------------------------------------------------------------
module tpf_ptrs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic                 operation,
  input  logic [1:0]           priority_req,
  output tpf_pkg::mem_cmd_t    cmd
);

  logic [tpf_pkg::PTR_W-1:0] rd_pos [tpf_pkg::LEVELS];
  logic [tpf_pkg::PTR_W-1:0] wr_pos [tpf_pkg::LEVELS];
  logic [tpf_pkg::CNT_W-1:0] fill   [tpf_pkg::LEVELS];

  logic [tpf_pkg::LVL_W-1:0] push_lvl;
  logic [tpf_pkg::LVL_W-1:0] pop_lvl;
  logic                      any_full;
  logic                      any_data;
  logic [tpf_pkg::LVL_W-1:0] sel_lvl;
  logic [tpf_pkg::PTR_W-1:0] sel_pos;

  function automatic logic [tpf_pkg::PTR_W-1:0] advance(
    input logic [tpf_pkg::PTR_W-1:0] pos
  );
    advance = (pos == tpf_pkg::PTR_W'(tpf_pkg::DEPTH - 1)) ?
              '0 : pos + tpf_pkg::PTR_W'(1);
  endfunction

  always_comb begin
    case (priority_req)
      tpf_pkg::PRIO_ONE: push_lvl = tpf_pkg::LVL_ONE;
      tpf_pkg::PRIO_TWO: push_lvl = tpf_pkg::LVL_TWO;
      default:           push_lvl = tpf_pkg::LVL_THREE;
    endcase
  end

  // Most urgent non-empty level
  always_comb begin
    any_data = 1'b1;
    if (fill[tpf_pkg::LVL_ONE] != '0) begin
      pop_lvl = tpf_pkg::LVL_ONE;
    end else if (fill[tpf_pkg::LVL_TWO] != '0) begin
      pop_lvl = tpf_pkg::LVL_TWO;
    end else begin
      pop_lvl  = tpf_pkg::LVL_THREE;
      any_data = (fill[tpf_pkg::LVL_THREE] != '0);
    end
  end

  assign any_full = (fill[push_lvl] == tpf_pkg::CNT_W'(tpf_pkg::DEPTH));
  assign sel_lvl  = (operation == tpf_pkg::OP_POP) ? pop_lvl : push_lvl;
  assign sel_pos  = (operation == tpf_pkg::OP_POP) ? rd_pos[pop_lvl] : wr_pos[push_lvl];

  always_comb begin
    cmd.addr = tpf_pkg::ADDR_W'(sel_lvl) * tpf_pkg::ADDR_W'(tpf_pkg::DEPTH)
             + tpf_pkg::ADDR_W'(sel_pos);
    if (operation == tpf_pkg::OP_POP) begin
      cmd.wr_en  = 1'b0;
      cmd.rd_en  = any_data;
      cmd.status = any_data ? tpf_pkg::ST_POP_OK : tpf_pkg::ST_ALL_EMPTY;
    end else begin
      cmd.wr_en  = !any_full;
      cmd.rd_en  = 1'b0;
      cmd.status = any_full ? tpf_pkg::ST_OVERFLOW : tpf_pkg::ST_PUSH_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tpf_pkg::LEVELS; i++) begin
        rd_pos[i] <= '0;
        wr_pos[i] <= '0;
        fill[i]   <= '0;
      end
    end else if (take) begin
      if (cmd.wr_en) begin
        wr_pos[push_lvl] <= advance(wr_pos[push_lvl]);
        fill[push_lvl]   <= fill[push_lvl] + tpf_pkg::CNT_W'(1);
      end
      if (cmd.rd_en) begin
        rd_pos[pop_lvl] <= advance(rd_pos[pop_lvl]);
        fill[pop_lvl]   <= fill[pop_lvl] - tpf_pkg::CNT_W'(1);
      end
    end
  end

endmodule

// ===== test/tb_three_level_priority_fifo_core.sv =====
// ----------------------------------------------------------------------------
// tb_three_level_priority_fifo_core
// Self-checking bench: pushes and pops go in on s_, a ring-based copy of the
// three priority levels predicts every response, and the m_ side is checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_three_level_priority_fifo_core;
  import tpf_pkg::*;

  localparam int REQ_TARGET = 1850;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic [1:0] prio;
  } req_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic [1:0] status;
  } resp_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic [2:0] s_tuser = 3'b000;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;

  three_level_priority_fifo_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Shadow of the three rings
  logic [7:0] ring_bytes [LEVELS][DEPTH];
  int         ring_head  [LEVELS];
  int         ring_tail  [LEVELS];
  int         ring_fill  [LEVELS];

  req_t  request_queue[$];
  resp_t owed_responses[$];
  req_t  cur_req;

  int errors = 0;
  int n_push_ok = 0, n_overflow = 0, n_pop_ok = 0, n_all_empty = 0;
  int n_checked = 0;

  // Work out the response to one accepted request and update the shadow rings
  function automatic void arbitrate_request(input req_t r);
    logic [LVL_W-1:0] lvl;
    resp_t            rsp;
    bit               served;
    rsp = '0;
    served = 1'b0;
    if (r.op == OP_PUSH) begin
      if (r.prio == PRIO_ONE)      lvl = LVL_ONE;
      else if (r.prio == PRIO_TWO) lvl = LVL_TWO;
      else                         lvl = LVL_THREE;
      rsp.result_byte = 8'h00;
      if (ring_fill[lvl] >= DEPTH) begin
        rsp.status = ST_OVERFLOW;
        n_overflow++;
      end else begin
        ring_bytes[lvl][ring_tail[lvl]] = r.data;
        ring_tail[lvl] = (ring_tail[lvl] + 1 >= DEPTH) ? 0 : ring_tail[lvl] + 1;
        ring_fill[lvl]++;
        rsp.status = ST_PUSH_OK;
        n_push_ok++;
      end
    end else begin
      // most urgent non-empty level wins
      for (int k = 0; k < LEVELS; k++) begin
        if (!served && ring_fill[k] != 0) begin
          rsp.result_byte = ring_bytes[k][ring_head[k]];
          ring_head[k] = (ring_head[k] + 1 >= DEPTH) ? 0 : ring_head[k] + 1;
          ring_fill[k]--;
          rsp.status = ST_POP_OK;
          served = 1'b1;
          n_pop_ok++;
        end
      end
      if (!served) begin
        rsp.result_byte = EMPTY_BYTE;
        rsp.status = ST_ALL_EMPTY;
        n_all_empty++;
      end
    end
    owed_responses.push_back(rsp);
  endfunction

  task automatic add_req(input logic op, input logic [7:0] data, input logic [1:0] prio);
    req_t r;
    r.op = op;
    r.data = data;
    r.prio = prio;
    request_queue.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of back-to-back requests separated by random idle gaps.
  // A request is handed to the predictor at the edge its transaction completes.
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int idle_left  = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        arbitrate_request(cur_req);
      end
      if (!s_tvalid || s_tready) begin
        if (idle_left > 0 || request_queue.size() == 0) begin
          if (idle_left > 0) idle_left--;
          s_tvalid <= 1'b0;
          // junk on the data lines while idle
          s_tdata  <= 8'($urandom_range(0, 255));
          s_tuser  <= 3'($urandom_range(0, 7));
        end else begin
          cur_req = request_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cur_req.data;
          s_tuser  <= {cur_req.prio, cur_req.op};
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            // one burst in four runs straight into the next
            idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each response transaction against the oldest prediction.
  // m_tready follows a 32-bit pattern reloaded with a random flavor:
  // always ready, mostly ready, coin flip, or mostly stalled.
  // --------------------------------------------------------------------------
  logic [31:0] ready_pattern = '0;
  int          pattern_left  = 0;
  resp_t       want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_responses.size() == 0) begin
          $error("unexpected response: result_byte %h status %0d", m_tdata, m_tuser);
          errors++;
        end else begin
          want = owed_responses.pop_front();
          n_checked++;
          if (m_tdata !== want.result_byte) begin
            $error("result_byte mismatch: expected %h, got %h", want.result_byte, m_tdata);
            errors++;
          end
          if (m_tuser !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
            errors++;
          end
        end
      end
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pattern = '1;
          1:       ready_pattern = $urandom | $urandom;
          2:       ready_pattern = $urandom;
          default: ready_pattern = $urandom & $urandom;
        endcase
        pattern_left = 32;
      end
      m_tready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
      pattern_left--;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int          n_left;
    int          push_pct;
    int          n_total;
    logic [1:0]  lvl_prio;
    for (int k = 0; k < LEVELS; k++) begin
      ring_head[k] = 0;
      ring_tail[k] = 0;
      ring_fill[k] = 0;
    end

    // Directed: pop from empty, one push per priority code with edge data,
    // least urgent first so the pops must reorder, then empty again.
    add_req(OP_POP,  8'hFF, 2'd0);
    add_req(OP_PUSH, 8'h00, 2'd0);
    add_req(OP_PUSH, 8'hFF, 2'd3);
    add_req(OP_PUSH, 8'hA5, PRIO_TWO);
    add_req(OP_PUSH, 8'h5A, PRIO_ONE);
    add_req(OP_POP,  8'h00, 2'd3);
    add_req(OP_POP,  8'hFF, PRIO_ONE);
    add_req(OP_POP,  8'h00, PRIO_TWO);
    add_req(OP_POP,  8'hFF, 2'd0);
    add_req(OP_POP,  8'h00, 2'd0);

    // Random: fill runs past full (overflow, wrap), drain runs past empty,
    // and mixed traffic with a varying push/pop balance.
    while (request_queue.size() < REQ_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          lvl_prio = 2'($urandom_range(0, 3));
          n_left = DEPTH + $urandom_range(0, 3);
          repeat (n_left) add_req(OP_PUSH, 8'($urandom_range(0, 255)), lvl_prio);
        end
        3, 4: begin
          n_left = $urandom_range(1, 3 * DEPTH + 4);
          repeat (n_left)
            add_req(OP_POP, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
        end
        default: begin
          push_pct = $urandom_range(30, 70);
          n_left = $urandom_range(1, 40);
          repeat (n_left)
            add_req(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
                    8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
        end
      endcase
    end
    n_total = request_queue.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // every request yields one response; wait until all have been checked
    while (n_checked < n_total) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("checked %0d responses: %0d pushes, %0d overflows, %0d pops, %0d empty pops",
             n_checked, n_push_ok, n_overflow, n_pop_ok, n_all_empty);
    if (errors == 0) begin
      $display("three_level_priority_fifo_core regression: pass");
    end else begin
      $display("three_level_priority_fifo_core regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("timeout with %0d responses outstanding", owed_responses.size());
    $display("three_level_priority_fifo_core regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tpf_pkg.sv
rtl/core/tpf_ram.sv
rtl/core/tpf_ptrs.sv
rtl/core/three_level_priority_fifo_core.sv
test/tb_three_level_priority_fifo_core.sv
